@@ rtl/sma_pkg.sv @@
// ----------------------------------------------------------------------------
// sma_pkg
// Shared opcodes, status codes and control types for the stack machine ALU.
// ----------------------------------------------------------------------------
package sma_pkg;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MOD  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	localparam int WORD_W  = 32;
	localparam int DEPTH_W = 7;

	typedef struct packed {
		logic start;
		logic is_mod;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/stack_machine_arith_unit_top.sv @@
// ----------------------------------------------------------------------------
// stack_machine_arith_unit_top
// Bounded stack of signed 32-bit words executing push and arithmetic requests.
// ----------------------------------------------------------------------------
// Each request carries one instruction and produces exactly one result that
// reports the status, the new top of stack (zero when empty) and the depth.
// The top entry lives in a register and the entries below it in a RAM with a
// registered read, so a binary operation needs a single RAM read of the
// second entry. One request is worked on at a time. A push, an unused
// opcode or any error goes from acceptance straight to the done state. Add,
// sub and mul first pass through the read state for the RAM read. Div and
// mod pass through the read state and then wait in the divide state: the
// divider retires one quotient bit per cycle, then applies the sign fixup,
// and the result is handed back through the done state. A finished result
// waits in an output register, and the next request is accepted while it
// waits; a second finished result holds the input stalled until the first
// one is taken. The stack RAM needs no clearing: only entries below the
// depth count are ever read.
// ----------------------------------------------------------------------------
module stack_machine_arith_unit_top #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  opcode,
	input  logic signed [31:0]          push_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic signed [31:0]          top_value,
	output logic [sma_pkg::DEPTH_W-1:0] stack_depth
);

	import sma_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [2:0]          op_q;
	status_t             status_q;
	logic [CW-1:0]       cnt_q;
	logic [WORD_W-1:0]   top_q;

	logic                out_valid_q;
	status_t             status_out_q;
	logic [WORD_W-1:0]   top_out_q;
	logic [DEPTH_W-1:0]  depth_out_q;

	logic                accept;
	logic                out_free;
	logic                is_binary;
	logic                full;
	logic                short;
	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       cnt_m2;
	logic [CW+DEPTH_W-1:0] cnt_ext;

	logic                ram_we;
	logic                ram_re;
	logic [WORD_W-1:0]   ram_rdata;
	logic [2*WORD_W-1:0] prod;

	div_ctrl_t           div_ctrl;
	div_stat_t           div_stat;
	logic [WORD_W-1:0]   div_result;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (cnt_q == CW'(STACK_DEPTH));
	assign short     = (cnt_q < CW'(2));
	assign cnt_m1    = cnt_q - CW'(1);
	assign cnt_m2    = cnt_q - CW'(2);
	assign cnt_ext   = {{DEPTH_W{1'b0}}, cnt_q};

	always_comb begin
		case (opcode)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: is_binary = 1'b1;
			default:                                is_binary = 1'b0;
		endcase
	end

	// A push spills the old top into the RAM; a binary op fetches the second entry.
	assign ram_we = accept && (opcode == OP_PUSH) && !full && (cnt_q != '0);
	assign ram_re = accept && is_binary && !short;

	sma_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_m1[AW-1:0]),
		.wdata (top_q),
		.re    (ram_re),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign div_ctrl.start  = (state_q == S_READ) && ((op_q == OP_DIV) || (op_q == OP_MOD));
	assign div_ctrl.is_mod = (op_q == OP_MOD);

	sma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (ram_rdata),
		.divisor  (top_q),
		.stat     (div_stat),
		.result   (div_result)
	);

	// The low word of the product is the same for signed and unsigned operands.
	assign prod = ram_rdata * top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			// The output register is loaded when a result is finished and the
			// register is free, and it empties once its result is taken.
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= opcode;
						status_q <= ST_OK;
						state_q  <= S_DONE;
						if (opcode == OP_PUSH) begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								top_q <= push_value;
								cnt_q <= cnt_q + CW'(1);
							end
						end else if (is_binary) begin
							if (short) begin
								status_q <= ST_SHORT;
							end else if (((opcode == OP_DIV) || (opcode == OP_MOD))
								&& (top_q == '0)) begin
								status_q <= ST_DIVZERO;
							end else begin
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					case (op_q)
						OP_ADD: begin
							top_q   <= ram_rdata + top_q;
							cnt_q   <= cnt_m1;
							state_q <= S_DONE;
						end
						OP_SUB: begin
							top_q   <= ram_rdata - top_q;
							cnt_q   <= cnt_m1;
							state_q <= S_DONE;
						end
						OP_MUL: begin
							top_q   <= prod[WORD_W-1:0];
							cnt_q   <= cnt_m1;
							state_q <= S_DONE;
						end
						default: state_q <= S_DIV;
					endcase
				end
				S_DIV: begin
					if (div_stat.done) begin
						top_q   <= div_result;
						cnt_q   <= cnt_m1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						status_out_q <= status_q;
						top_out_q    <= (cnt_q != '0) ? top_q : '0;
						depth_out_q  <= cnt_ext[DEPTH_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_out_q;
	assign top_value   = top_out_q;
	assign stack_depth = depth_out_q;

endmodule

@@ rtl/sma_ram.sv @@
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sma_div.sv @@
// ----------------------------------------------------------------------------
// sma_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sma_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sma_pkg::div_ctrl_t        ctrl,
	input  logic [sma_pkg::WORD_W-1:0] dividend,
	input  logic [sma_pkg::WORD_W-1:0] divisor,
	output sma_pkg::div_stat_t        stat,
	output logic [sma_pkg::WORD_W-1:0] result
);

	import sma_pkg::*;

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIX
	} dstate_t;

	localparam int CNT_W = $clog2(WORD_W);

	dstate_t             state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [WORD_W:0]     rem_q;
	logic [WORD_W-1:0]   quo_q;
	logic [WORD_W-1:0]   ub_q;
	logic                neg_q;
	logic                mod_q;
	logic                done_q;
	logic [WORD_W-1:0]   result_q;

	logic [WORD_W:0]     rem_sh;
	logic [WORD_W:0]     rem_sub;
	logic [WORD_W-1:0]   ua;
	logic [WORD_W-1:0]   ub;
	logic [WORD_W-1:0]   mag_res;

	assign ua      = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
	assign ub      = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
	assign rem_sh  = {rem_q[WORD_W-1:0], quo_q[WORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, ub_q};
	assign mag_res = mod_q ? rem_q[WORD_W-1:0] : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (ctrl.start) begin
						rem_q   <= '0;
						quo_q   <= ua;
						ub_q    <= ub;
						mod_q   <= ctrl.is_mod;
						// The remainder follows the dividend, the quotient the sign product.
						neg_q   <= ctrl.is_mod ? dividend[WORD_W-1]
							: (dividend[WORD_W-1] ^ divisor[WORD_W-1]);
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (!rem_sub[WORD_W]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[WORD_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[WORD_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(WORD_W - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					result_q <= neg_q ? (WORD_W'(0) - mag_res) : mag_res;
					done_q   <= 1'b1;
					state_q  <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != D_IDLE);
	assign stat.done = done_q;
	assign result    = result_q;

endmodule
